>>> rtl/csrcsc_pkg.sv
// Shared types, sizes and codes for the sparse row-to-column form converter.
// Used by csrcsc_conv and sparse_csr_to_csc_convert_core; depends on nothing.
`timescale 1ns / 1ps

package csrcsc_pkg;

    localparam int MAX_NONZEROS  = 1024;
    localparam int MAX_DIMENSION = 256;

    localparam int ENT_AW = $clog2(MAX_NONZEROS);       // entry store address
    localparam int CNT_W  = $clog2(MAX_NONZEROS) + 1;    // counts, pointers, totals
    localparam int COL_AW = $clog2(MAX_DIMENSION);       // column index
    localparam int PTR_AW = $clog2(MAX_DIMENSION) + 1;   // pointer table address
    localparam int ROW_W  = 8;
    localparam int COL_W  = 8;
    localparam int VAL_W  = 64;
    localparam int DIM_W  = 9;
    localparam int POS_W  = 11;

    localparam logic [CNT_W-1:0] NZ_LIMIT = CNT_W'(MAX_NONZEROS);
    localparam logic [DIM_W-1:0] DIM_MAX  = DIM_W'(MAX_DIMENSION);
    localparam logic [DIM_W-1:0] DIM_RST  = DIM_W'(256);

    // Item kinds
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_COL_OOR  = 2'd2;

    typedef struct packed {
        logic [VAL_W-1:0] bits;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } t_entry;

    // Core to conversion engine
    typedef struct packed {
        logic             start;
        logic             rd_en;
        logic [POS_W-1:0] rd_pos;
    } t_conv_req;

    // Conversion engine to core
    typedef struct packed {
        logic              done;
        logic              ld_rd_en;
        logic [ENT_AW-1:0] ld_addr;
    } t_conv_sts;

    // Clamp the dimension register into 1..MAX_DIMENSION
    function automatic logic [DIM_W-1:0] dim_of(input logic [DIM_W-1:0] cfg);
        logic [DIM_W-1:0] d;
        if (cfg == '0) begin
            d = DIM_W'(1);
        end else if (cfg > DIM_MAX) begin
            d = DIM_MAX;
        end else begin
            d = cfg;
        end
        return d;
    endfunction

endpackage

>>> rtl/csrcsc_conv.sv
// Conversion engine: per-column counts, prefix sum and stable scatter.
// Owns the count/cursor, column pointer and column-ordered stores; uses csrcsc_pkg.
`timescale 1ns / 1ps

module csrcsc_conv (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  csrcsc_pkg::t_conv_req         i_req,
    input  logic [csrcsc_pkg::DIM_W-1:0]  i_n,
    input  logic [csrcsc_pkg::CNT_W-1:0]  i_total,
    input  csrcsc_pkg::t_entry            i_ld_q,
    output csrcsc_pkg::t_conv_sts         o_sts,
    output logic [csrcsc_pkg::CNT_W-1:0]  o_ptr_q,
    output logic [csrcsc_pkg::ROW_W-1:0]  o_row_q,
    output logic [csrcsc_pkg::VAL_W-1:0]  o_bits_q
);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_CLEAR  = 11'b00000000010,
        S_CNT_RD = 11'b00000000100,
        S_CNT_AD = 11'b00000001000,
        S_CNT_WR = 11'b00000010000,
        S_PFX_RD = 11'b00000100000,
        S_PFX_WR = 11'b00001000000,
        S_SCT_RD = 11'b00010000000,
        S_SCT_AD = 11'b00100000000,
        S_SCT_WR = 11'b01000000000,
        S_DONE   = 11'b10000000000
    } t_state;

    typedef struct packed {
        logic [csrcsc_pkg::ROW_W-1:0] row;
        logic [csrcsc_pkg::VAL_W-1:0] bits;
    } t_sorted;

    t_state                        r_state, n_state;
    logic [csrcsc_pkg::CNT_W-1:0]  r_idx, n_idx;
    logic [csrcsc_pkg::CNT_W-1:0]  r_sum, n_sum;
    logic [csrcsc_pkg::COL_AW-1:0] r_col, n_col;

    // Count store doubles as the scatter cursor after the prefix pass
    logic [csrcsc_pkg::CNT_W-1:0]  r_cnt_mem [csrcsc_pkg::MAX_DIMENSION];
    logic [csrcsc_pkg::CNT_W-1:0]  r_cnt_q;
    logic [csrcsc_pkg::CNT_W-1:0]  r_ptr_mem [csrcsc_pkg::MAX_DIMENSION + 1];
    t_sorted                       r_srt_mem [csrcsc_pkg::MAX_NONZEROS];
    t_sorted                       r_srt_q;

    logic                          cnt_we, cnt_re, ptr_we, srt_we;
    logic [csrcsc_pkg::COL_AW-1:0] cnt_wa, cnt_ra;
    logic [csrcsc_pkg::CNT_W-1:0]  cnt_wd, ptr_wd, sum_nx;
    logic [csrcsc_pkg::PTR_AW-1:0] ptr_wa;
    logic                          col_ok, last_col, at_total;

    assign col_ok   = {1'b0, i_ld_q.col} < i_n;
    assign last_col = r_idx == {{(csrcsc_pkg::CNT_W - csrcsc_pkg::DIM_W){1'b0}}, i_n - 9'd1};
    assign at_total = r_idx == i_total;
    assign sum_nx   = r_sum + r_cnt_q;

    always_comb begin
        n_state        = r_state;
        n_idx          = r_idx;
        n_sum          = r_sum;
        n_col          = r_col;
        cnt_we         = 1'b0;
        cnt_wa         = r_idx[csrcsc_pkg::COL_AW-1:0];
        cnt_wd         = '0;
        cnt_re         = 1'b0;
        cnt_ra         = r_idx[csrcsc_pkg::COL_AW-1:0];
        ptr_we         = 1'b0;
        ptr_wa         = r_idx[csrcsc_pkg::PTR_AW-1:0];
        ptr_wd         = '0;
        srt_we         = 1'b0;
        o_sts.done     = 1'b0;
        o_sts.ld_rd_en = 1'b0;
        o_sts.ld_addr  = r_idx[csrcsc_pkg::ENT_AW-1:0];
        case (r_state)
            S_IDLE: begin
                if (i_req.start) begin
                    n_idx   = '0;
                    n_state = S_CLEAR;
                end
            end
            // Zero counts and pointers of columns 0..n-1
            S_CLEAR: begin
                cnt_we = 1'b1;
                ptr_we = 1'b1;
                if (last_col) begin
                    n_idx   = '0;
                    n_state = S_CNT_RD;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_CNT_RD: begin
                if (at_total) begin
                    n_idx   = '0;
                    n_sum   = '0;
                    n_state = S_PFX_RD;
                end else begin
                    o_sts.ld_rd_en = 1'b1;
                    n_state        = S_CNT_AD;
                end
            end
            S_CNT_AD: begin
                n_col  = i_ld_q.col;
                cnt_ra = i_ld_q.col;
                if (col_ok) begin
                    cnt_re  = 1'b1;
                    n_state = S_CNT_WR;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_CNT_RD;
                end
            end
            S_CNT_WR: begin
                cnt_we  = 1'b1;
                cnt_wa  = r_col;
                cnt_wd  = r_cnt_q + 1'b1;
                n_idx   = r_idx + 1'b1;
                n_state = S_CNT_RD;
            end
            S_PFX_RD: begin
                cnt_re  = 1'b1;
                n_state = S_PFX_WR;
            end
            // Column start goes back into the count store as the cursor
            S_PFX_WR: begin
                cnt_we = 1'b1;
                cnt_wd = r_sum;
                ptr_we = 1'b1;
                ptr_wa = r_idx[csrcsc_pkg::PTR_AW-1:0] + 1'b1;
                ptr_wd = sum_nx;
                n_sum  = sum_nx;
                if (last_col) begin
                    n_idx   = '0;
                    n_state = S_SCT_RD;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_PFX_RD;
                end
            end
            S_SCT_RD: begin
                if (at_total) begin
                    n_state = S_DONE;
                end else begin
                    o_sts.ld_rd_en = 1'b1;
                    n_state        = S_SCT_AD;
                end
            end
            S_SCT_AD: begin
                n_col  = i_ld_q.col;
                cnt_ra = i_ld_q.col;
                if (col_ok) begin
                    cnt_re  = 1'b1;
                    n_state = S_SCT_WR;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_SCT_RD;
                end
            end
            // Place the entry at its column cursor and advance the cursor
            S_SCT_WR: begin
                if (r_cnt_q < csrcsc_pkg::NZ_LIMIT) begin
                    srt_we = 1'b1;
                    cnt_we = 1'b1;
                    cnt_wa = r_col;
                    cnt_wd = r_cnt_q + 1'b1;
                end
                n_idx   = r_idx + 1'b1;
                n_state = S_SCT_RD;
            end
            S_DONE: begin
                o_sts.done = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_sum   <= '0;
            r_col   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_sum   <= n_sum;
            r_col   <= n_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            r_cnt_mem[cnt_wa] <= cnt_wd;
        end
        if (cnt_re) begin
            r_cnt_q <= r_cnt_mem[cnt_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ptr_we) begin
            r_ptr_mem[ptr_wa] <= ptr_wd;
        end
        if (i_req.rd_en) begin
            o_ptr_q <= r_ptr_mem[i_req.rd_pos[csrcsc_pkg::PTR_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (srt_we) begin
            r_srt_mem[r_cnt_q[csrcsc_pkg::ENT_AW-1:0]] <= '{row: i_ld_q.row, bits: i_ld_q.bits};
        end
        if (i_req.rd_en) begin
            r_srt_q <= r_srt_mem[i_req.rd_pos[csrcsc_pkg::ENT_AW-1:0]];
        end
    end

    assign o_row_q  = r_srt_q.row;
    assign o_bits_q = r_srt_q.bits;

endmodule

>>> rtl/sparse_csr_to_csc_convert_core.sv
// Top level of the sparse row-to-column form converter: stream ports, entry store,
// result register. Uses csrcsc_pkg and instantiates csrcsc_conv.
`timescale 1ns / 1ps

// A square sparse matrix is streamed in one nonzero per item, in row order, and
// is sorted into column-major compressed form by counting sort. A load item
// (tuser = 0) stores row, column and 64 value bits in arrival order and returns
// one result item with its status: ok, entry store full (1024 entries), or
// column not below n; flagged entries are dropped. The load item marked with
// tlast then runs the conversion, and its result carries conversion_done = 1.
// A read item (tuser = 1) returns the column pointer at read_position (zero
// beyond n) and the row and value bits of the column-ordered entry there (zero
// at or beyond the entry count); before any conversion a read returns zeros.
// A load after a finished conversion starts a new matrix. The dimension n comes
// from the configuration channel (reset 256, 0 acts as 1, above 256 as 256); it
// is to be written only while no item is in flight, which the user must ensure:
// the block itself does not enforce it. A plain load writes the entry store, a
// plain read registers its store reads, as the item is accepted; the item then
// passes a wait state, and the result register loads once the output is free.
// The input is not ready until then, but a new item is taken while the previous
// result still waits downstream. The conversion steps one shared index counter
// over the count store's single read port: it clears n columns, counts the stored
// entries, forms the prefix sum and scatters the entries, with the input not ready.
module sparse_csr_to_csc_convert_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: dimension n
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [8:0]  i_cfg_data,
    // Input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] row_index, [15:8] column_index, [79:16] entry_bits,
    // [90:80] read_position, [95:91] zero
    input  logic [95:0] s_axis_tdata,
    input  logic        s_axis_tuser,   // [0] op
    input  logic        s_axis_tlast,   // last_entry
    // Result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [1:0] status, [2] conversion_done, [13:3] column_start,
    // [21:14] result_row, [85:22] result_bits, [87:86] zero
    output logic [87:0] m_axis_tdata
);

    typedef enum logic [3:0] {
        T_IDLE = 4'b0001,
        T_PEND = 4'b0010,
        T_CONV = 4'b0100,
        T_OUT  = 4'b1000
    } t_state;

    t_state                            r_state, n_state;
    logic [csrcsc_pkg::DIM_W-1:0]      r_cfg;
    logic [csrcsc_pkg::CNT_W-1:0]      r_total;
    logic                              r_done;
    logic                              r_op;
    logic [1:0]                        r_status;
    logic                              r_ptr_ok, r_ent_ok;
    logic [csrcsc_pkg::DIM_W-1:0]      r_conv_dim;
    logic                              r_out_valid;
    logic [87:0]                       r_out_data;

    csrcsc_pkg::t_entry                r_ld_mem [csrcsc_pkg::MAX_NONZEROS];
    csrcsc_pkg::t_entry                r_ld_q;

    csrcsc_pkg::t_conv_req             conv_req;
    csrcsc_pkg::t_conv_sts             conv_sts;
    logic [csrcsc_pkg::CNT_W-1:0]      ptr_q;
    logic [csrcsc_pkg::ROW_W-1:0]      row_q;
    logic [csrcsc_pkg::VAL_W-1:0]      bits_q;

    logic [csrcsc_pkg::DIM_W-1:0]      dim;
    logic                              accept, out_free, is_load;
    logic [csrcsc_pkg::ROW_W-1:0]      in_row;
    logic [csrcsc_pkg::COL_W-1:0]      in_col;
    logic [csrcsc_pkg::VAL_W-1:0]      in_bits;
    logic [csrcsc_pkg::POS_W-1:0]      in_pos;
    logic [csrcsc_pkg::CNT_W-1:0]      eff_total;
    logic                              col_oor, st_full, ld_keep;
    logic [10:0]                       res_start;
    logic [7:0]                        res_row;
    logic [63:0]                       res_bits;

    assign dim       = csrcsc_pkg::dim_of(r_cfg);
    assign in_row    = s_axis_tdata[7:0];
    assign in_col    = s_axis_tdata[15:8];
    assign in_bits   = s_axis_tdata[79:16];
    assign in_pos    = s_axis_tdata[90:80];

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == T_IDLE);
    assign accept        = s_axis_tvalid & s_axis_tready;
    assign is_load       = (s_axis_tuser == csrcsc_pkg::OP_LOAD);
    assign out_free      = !r_out_valid || m_axis_tready;

    // A load after a finished conversion restarts the entry count
    assign eff_total = r_done ? '0 : r_total;
    assign col_oor   = {1'b0, in_col} >= dim;
    assign st_full   = eff_total >= csrcsc_pkg::NZ_LIMIT;
    assign ld_keep   = accept && is_load && !col_oor && !st_full;

    assign conv_req.start  = accept && is_load && s_axis_tlast;
    assign conv_req.rd_en  = accept && !is_load;
    assign conv_req.rd_pos = in_pos;

    always_comb begin
        n_state = r_state;
        case (r_state)
            T_IDLE: begin
                if (accept) begin
                    n_state = conv_req.start ? T_CONV : T_PEND;
                end
            end
            T_PEND: begin
                n_state = T_OUT;
            end
            T_CONV: begin
                if (conv_sts.done) begin
                    n_state = T_OUT;
                end
            end
            T_OUT: begin
                if (out_free) begin
                    n_state = T_IDLE;
                end
            end
            default: begin
                n_state = T_IDLE;
            end
        endcase
    end

    // Read results keep zeros where the position is out of range
    always_comb begin
        res_start = '0;
        res_row   = '0;
        res_bits  = '0;
        if (r_op == csrcsc_pkg::OP_READ) begin
            if (r_ptr_ok) begin
                res_start = ptr_q;
            end
            if (r_ent_ok) begin
                res_row  = row_q;
                res_bits = bits_q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= T_IDLE;
            r_cfg       <= csrcsc_pkg::DIM_RST;
            r_total     <= '0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cfg <= i_cfg_data;
            end
            if (accept && is_load) begin
                r_done  <= 1'b0;
                r_total <= ld_keep ? eff_total + 1'b1 : eff_total;
            end
            if (r_state == T_CONV && conv_sts.done) begin
                r_done <= 1'b1;
            end
            if (r_state == T_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Item fields held for the result; pointers above the dimension of the
    // last conversion were not written by it, so read them as zero
    always_ff @(posedge i_clk) begin
        if (conv_req.start) begin
            r_conv_dim <= dim;
        end
        if (accept) begin
            r_op     <= s_axis_tuser;
            r_ptr_ok <= r_done && (in_pos <= {2'b0, dim}) && (in_pos <= {2'b0, r_conv_dim});
            r_ent_ok <= r_done && (in_pos < r_total);
            if (!is_load) begin
                r_status <= csrcsc_pkg::ST_OK;
            end else if (col_oor) begin
                r_status <= csrcsc_pkg::ST_COL_OOR;
            end else if (st_full) begin
                r_status <= csrcsc_pkg::ST_FULL;
            end else begin
                r_status <= csrcsc_pkg::ST_OK;
            end
        end
        if (r_state == T_OUT && out_free) begin
            r_out_data <= {2'b00, res_bits, res_row, res_start, r_done, r_status};
        end
    end

    // Arrival-order entry store: written on loads, read by the conversion engine
    always_ff @(posedge i_clk) begin
        if (ld_keep) begin
            r_ld_mem[eff_total[csrcsc_pkg::ENT_AW-1:0]] <=
                '{bits: in_bits, col: in_col, row: in_row};
        end
        if (conv_sts.ld_rd_en) begin
            r_ld_q <= r_ld_mem[conv_sts.ld_addr];
        end
    end

    csrcsc_conv u_conv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (conv_req),
        .i_n      (dim),
        .i_total  (r_total),
        .i_ld_q   (r_ld_q),
        .o_sts    (conv_sts),
        .o_ptr_q  (ptr_q),
        .o_row_q  (row_q),
        .o_bits_q (bits_q)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for sparse_csr_to_csc_convert_core: drives matrices in row order,
// reads back the column form and compares every result item with its own predictor.
// Depends on csrcsc_pkg and the core RTL only.

module testbench;
    import csrcsc_pkg::*;

    localparam int LONG_HOLD  = 400;     // receiver hold-off that backs up the core
    localparam int IDLE_LIMIT = 50000;   // longest allowed run with no transfer
    localparam int ITEM_GOAL  = 1900;

    typedef struct packed {
        logic [1:0]       status;
        logic             done;
        logic [POS_W-1:0] col_start;
        logic [ROW_W-1:0] row;
        logic [VAL_W-1:0] bits;
    } csc_result_t;

    // Predictor of the column form plus the queue of result items it owes.
    class csc_ledger;
        int unsigned      column_count = DIM_RST;
        logic [ROW_W-1:0] arrival_row [MAX_NONZEROS];
        logic [COL_W-1:0] arrival_col [MAX_NONZEROS];
        logic [VAL_W-1:0] arrival_bits[MAX_NONZEROS];
        int unsigned      col_ptr     [MAX_DIMENSION + 1];
        logic [ROW_W-1:0] sorted_row  [MAX_NONZEROS];
        logic [VAL_W-1:0] sorted_bits [MAX_NONZEROS];
        int unsigned      entry_total = 0;
        bit               converted = 1'b0;
        csc_result_t      results_due[$];
        int               failures = 0;
        int               result_count = 0;

        function int unsigned dim();
            if (column_count == 0) return 1;
            if (column_count > MAX_DIMENSION) return MAX_DIMENSION;
            return column_count;
        endfunction

        function void set_columns(logic [DIM_W-1:0] value);
            column_count = value;
        endfunction

        function int pending();
            return results_due.size();
        endfunction

        // Count per column, prefix-sum into start pointers, scatter stably.
        function void convert_columns();
            int unsigned n;
            int unsigned c;
            int unsigned dst;
            int unsigned next_slot[MAX_DIMENSION + 1];
            n = dim();
            foreach (col_ptr[i]) col_ptr[i] = 0;
            for (int k = 0; k < entry_total; k++) begin
                c = arrival_col[k];
                if (c < n) col_ptr[c + 1]++;
            end
            for (c = 1; c <= n; c++) col_ptr[c] += col_ptr[c - 1];
            next_slot = col_ptr;
            for (int k = 0; k < entry_total; k++) begin
                c = arrival_col[k];
                if (c >= n) continue;
                dst = next_slot[c];
                if (dst >= MAX_NONZEROS) continue;
                sorted_row[dst]  = arrival_row[k];
                sorted_bits[dst] = arrival_bits[k];
                next_slot[c] = dst + 1;
            end
            converted = 1'b1;
        endfunction

        function void take_item(logic op, logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                                logic [VAL_W-1:0] bits, logic last, logic [POS_W-1:0] pos);
            csc_result_t r;
            r = '0;
            r.status = ST_OK;
            if (op == OP_LOAD) begin
                // a load after a finished conversion opens a new matrix
                if (converted) begin
                    entry_total = 0;
                    converted = 1'b0;
                end
                if (col >= dim()) begin
                    r.status = ST_COL_OOR;
                end else if (entry_total >= MAX_NONZEROS) begin
                    r.status = ST_FULL;
                end else begin
                    arrival_row[entry_total]  = row;
                    arrival_col[entry_total]  = col;
                    arrival_bits[entry_total] = bits;
                    entry_total++;
                end
                if (last) convert_columns();
            end else if (converted) begin
                if (pos <= dim()) r.col_start = POS_W'(col_ptr[pos]);
                if (pos < entry_total) begin
                    r.row  = sorted_row[pos];
                    r.bits = sorted_bits[pos];
                end
            end
            r.done = converted;
            results_due.push_back(r);
        endfunction

        function void compare_field(string field, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                failures++;
                if (failures <= 10)
                    $display("result %0d: %s expected 0x%0h, got 0x%0h",
                             result_count, field, want, got);
            end
        endfunction

        function void check_result(logic [87:0] d);
            csc_result_t want;
            result_count++;
            if (results_due.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("result %0d arrived with nothing expected: 0x%0h",
                             result_count, d);
                return;
            end
            want = results_due.pop_front();
            compare_field("status", want.status, d[1:0]);
            compare_field("conversion_done", want.done, d[2]);
            compare_field("column_start", want.col_start, d[13:3]);
            compare_field("result_row", want.row, d[21:14]);
            compare_field("result_bits", want.bits, d[85:22]);
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [8:0]  i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [87:0] m_axis_tdata;

    csc_ledger ledger;
    bit        quiet = 1'b0;     // no random idling on either side while set
    int        items_sent = 0;
    int        hold_requests = 0;
    int        holds_done = 0;
    int        rx_stall_left = 0;
    int        idle_cycles = 0;

    always #5 i_clk = ~i_clk;

    sparse_csr_to_csc_convert_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 15);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [VAL_W-1:0] pick_bits();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return {$urandom, $urandom};
    endfunction

    function automatic logic [DIM_W-1:0] pick_columns();
        int r;
        r = $urandom_range(0, 19);
        if (r < 4) return DIM_W'(256);
        if (r < 6) return DIM_W'(1);
        if (r < 12) return DIM_W'($urandom_range(2, 16));
        if (r < 18) return DIM_W'($urandom_range(17, 255));
        if (r == 18) return '0;
        return DIM_W'($urandom_range(257, 511));
    endfunction

    function automatic logic [POS_W-1:0] pick_position(int n, int total);
        int r;
        r = $urandom_range(0, 9);
        if (r < 4 && total > 0) return POS_W'($urandom_range(0, total - 1));
        if (r < 7) return POS_W'($urandom_range(0, n + 1));
        if (r < 9) return POS_W'($urandom_range(0, 1024));
        case ($urandom_range(0, 4))
            0: return POS_W'(n);
            1: return POS_W'(n + 1);
            2: return POS_W'(total);
            3: return POS_W'(1024);
            default: return '0;
        endcase
    endfunction

    // Offer one item, hold it until taken, then note it and maybe idle.
    task automatic offer_item(input logic op, input logic [ROW_W-1:0] row,
                              input logic [COL_W-1:0] col, input logic [VAL_W-1:0] bits,
                              input logic last, input logic [POS_W-1:0] pos);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tlast  <= last;
        s_axis_tdata  <= {5'b0, pos, bits, col, row};
        do @(posedge i_clk); while (!s_axis_tready);
        ledger.take_item(op, row, col, bits, last, pos);
        items_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic load_entry(input int row, input int col, input logic [VAL_W-1:0] bits,
                              input logic last);
        offer_item(OP_LOAD, ROW_W'(row), COL_W'(col), bits, last,
                   POS_W'($urandom_range(0, 1024)));
    endtask

    // Row, column, value and last mark ride along as noise on a read.
    task automatic read_entry(input int pos);
        offer_item(OP_READ, ROW_W'($urandom), COL_W'($urandom), {$urandom, $urandom},
                   1'($urandom_range(0, 1)), POS_W'(pos));
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (ledger.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_columns(input logic [DIM_W-1:0] value);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        ledger.set_columns(value);
        i_cfg_valid <= 1'b0;
    endtask

    // One matrix, rows mostly in order, last load marked, then reads of the result.
    task automatic run_matrix(input int loads, input int reads, input bit pause_midway);
        int n;
        int row;
        int step;
        int col;
        n = ledger.dim();
        row = 0;
        for (int k = 0; k < loads; k++) begin
            if ($urandom_range(0, 99) < 4)
                read_entry(pick_position(n, ledger.entry_total));
            if (pause_midway && k == loads / 2) wait_drained();
            step = $urandom_range(0, 1);
            row = (row + step > n - 1) ? n - 1 : row + step;
            col = ($urandom_range(0, 99) < 85) ? $urandom_range(0, n - 1)
                                               : $urandom_range(0, 255);
            if ($urandom_range(0, 99) < 8)
                load_entry($urandom_range(0, 255), col, pick_bits(), k == loads - 1);
            else
                load_entry(row, col, pick_bits(), k == loads - 1);
        end
        for (int k = 0; k < reads; k++)
            read_entry(pick_position(n, ledger.entry_total));
    endtask

    // Receiver: check taken results, stall at random, honor long hold-off requests.
    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready)
            ledger.check_result(m_axis_tdata);
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (rx_stall_left > 0) begin
            rx_stall_left--;
            m_axis_tready <= 1'b0;
        end else if (hold_requests != holds_done) begin
            holds_done++;
            rx_stall_left = LONG_HOLD;
            m_axis_tready <= 1'b0;
        end else begin
            if (!quiet && $urandom_range(0, 99) < 30)
                rx_stall_left = pick_gap();
            m_axis_tready <= (rx_stall_left == 0);
        end
    end

    initial begin : watchdog
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                    || (i_cfg_valid && o_cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : stimulus
        int m;
        ledger = new;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: read before any conversion, then a full-width matrix
        read_entry(0);
        load_entry(0, 0, '0, 1'b0);
        load_entry(0, 255, '1, 1'b0);
        load_entry(1, 7, 64'hA5A5_5A5A_F00F_0FF0, 1'b0);
        load_entry(0, 7, 64'h0123_4567_89AB_CDEF, 1'b0);   // row out of order
        load_entry(255, 0, {$urandom, $urandom}, 1'b0);
        load_entry(255, 128, 64'h8000_0000_0000_0001, 1'b1);
        read_entry(0);
        read_entry(1);
        read_entry(5);
        read_entry(6);
        read_entry(7);
        read_entry(255);
        read_entry(256);
        read_entry(257);
        read_entry(1024);
        // Smallest dimension: second load is out of range and still converts
        write_columns(9'd1);
        load_entry(0, 0, {$urandom, $urandom}, 1'b0);
        load_entry(0, 1, {$urandom, $urandom}, 1'b1);
        read_entry(0);
        read_entry(1);
        read_entry(2);
        // Zero acts as one, oversize acts as full width
        write_columns(9'd0);
        load_entry(0, 1, {$urandom, $urandom}, 1'b1);
        read_entry(0);
        write_columns(9'd511);
        load_entry(3, 255, {$urandom, $urandom}, 1'b1);

        // Random matrices; the fifth overfills the entry store
        m = 0;
        while (items_sent < ITEM_GOAL) begin
            quiet = ($urandom_range(0, 4) == 0);
            if (m == 4) begin
                write_columns(DIM_W'(256));
                run_matrix(MAX_NONZEROS + 6, 80, 1'b0);
            end else begin
                if (m == 1 || m == 2 || $urandom_range(0, 2) == 0)
                    write_columns(pick_columns());
                if (m == 1) begin
                    // back the core up behind a stalled receiver
                    quiet = 1'b1;
                    hold_requests++;
                end
                run_matrix((m == 1) ? 40 : $urandom_range(1, 30), $urandom_range(4, 24),
                           m == 2);
            end
            m++;
        end
        quiet = 1'b0;

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (ledger.failures == 0 && ledger.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
